// ===== hdl/nsrc_pkg.sv =====
`timescale 1ns / 1ps

package nsrc_pkg;

  // Stream counters
  localparam int COUNT_BITS = 20;
  localparam int POS_W      = COUNT_BITS + 10;
  localparam int IN_W       = COUNT_BITS + 2;
  localparam int FRAC_BITS  = 8;

  // Chunk geometry
  localparam int CHUNK_SIZE = 1024;
  localparam int OFS_W      = $clog2(CHUNK_SIZE);

  // Results per source word
  localparam int MAX_RESULTS = 4;
  localparam int RUN_W       = $clog2(MAX_RESULTS);

  // Sample and step formats
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 11;
  localparam int STEP_MIN   = 64;
  localparam int STEP_MAX   = 1024;
  localparam int STEP_RESET = 256;

  // Source word queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_STEP  = 2'd0,
    REG_MODE  = 2'd1,
    REG_COUNT = 2'd2
  } reg_index_e;

  typedef enum logic {
    MODE_8BIT  = 1'b0,
    MODE_16BIT = 1'b1
  } width_mode_e;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic [STEP_W-1:0]     step;
    width_mode_e           mode;
    logic [COUNT_BITS-1:0] count;
  } cfg_t;

endpackage

// ===== hdl/nearest_sample_rate_converter.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// config    psel/penable/pwrite/pready paddr, pwdata, prdata
// input     in_valid_i / in_ready_o    raw_sample_i
// output    out_valid_o / out_ready_i  sample_out_o, chunk_offset_o, chunk_start_o,
//                                      run_last_o, stream_done_o
//
// In the back end a source word gives n (0 to 4) output words: it is pulled from the
// queue in BK_IDLE, then each of its output words is emitted in BK_EMIT.
// The front end converts words and buffers up to four of them in a queue.
// Reset is asynchronous and active low; it clears all counters and the queue.
// Either side may stall: the queue and the held output word decouple them.

module nearest_sample_rate_converter import nsrc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [SAMPLE_W-1:0]        raw_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic [OFS_W-1:0]           chunk_offset_o,
  output logic                       chunk_start_o,
  output logic                       run_last_o,
  output logic                       stream_done_o
);

  cfg_t                cfg;
  logic                q_valid, pop;
  logic [SAMPLE_W-1:0] q_sample;

  // Configuration registers.
  nsrc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input conversion and queue.
  nsrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (cfg.mode),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_sample_i (raw_sample_i),
    .pop_i        (pop),
    .q_valid_o    (q_valid),
    .q_sample_o   (q_sample)
  );

  // Resampling and output.
  nsrc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .q_sample_i     (q_sample),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_out_o   (sample_out_o),
    .chunk_offset_o (chunk_offset_o),
    .chunk_start_o  (chunk_start_o),
    .run_last_o     (run_last_o),
    .stream_done_o  (stream_done_o)
  );

endmodule

// ===== hdl/nsrc_cfg.sv =====
`timescale 1ns / 1ps

module nsrc_cfg import nsrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t              cfg_q, cfg_d;
  logic              wr_en;
  logic [1:0]        reg_idx;
  logic [STEP_W-1:0] step_raw;
  logic [STEP_W-1:0] step_sat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // The step register saturates to its legal range.
  assign step_raw = pwdata[STEP_W-1:0];
  always_comb begin
    if (step_raw < STEP_W'(STEP_MIN)) begin
      step_sat = STEP_W'(STEP_MIN);
    end else if (step_raw > STEP_W'(STEP_MAX)) begin
      step_sat = STEP_W'(STEP_MAX);
    end else begin
      step_sat = step_raw;
    end
  end

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_STEP:  cfg_d.step  = step_sat;
        REG_MODE:  cfg_d.mode  = width_mode_e'(pwdata[0]);
        REG_COUNT: cfg_d.count = pwdata[COUNT_BITS-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step  <= STEP_W'(STEP_RESET);
      cfg_q.mode  <= MODE_16BIT;
      cfg_q.count <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      REG_STEP:  prdata = PDATA_W'(cfg_q.step);
      REG_MODE:  prdata = PDATA_W'(cfg_q.mode);
      REG_COUNT: prdata = PDATA_W'(cfg_q.count);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/nsrc_front.sv =====
`timescale 1ns / 1ps

module nsrc_front import nsrc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  width_mode_e         mode_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] raw_sample_i,
  input  logic                pop_i,
  output logic                q_valid_o,
  output logic [SAMPLE_W-1:0] q_sample_o
);

  logic [SAMPLE_W-1:0] store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     fill_q, fill_d;
  logic [SAMPLE_W-1:0] conv;
  logic                push, pop;

  // Sample conversion: an 8-bit source is centered and moved to the top byte.
  always_comb begin
    if (mode_i == MODE_16BIT) begin
      conv = raw_sample_i;
    end else begin
      conv = {raw_sample_i[7:0] ^ 8'h80, 8'h00};
    end
  end

  assign in_ready_o = (fill_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid_o  = (fill_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && q_valid_o;
  assign q_sample_o = store_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= conv;
    end
  end

endmodule

// ===== hdl/nsrc_back.sv =====
`timescale 1ns / 1ps

module nsrc_back import nsrc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       q_valid_i,
  input  logic [SAMPLE_W-1:0]        q_sample_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic [OFS_W-1:0]           chunk_offset_o,
  output logic                       chunk_start_o,
  output logic                       run_last_o,
  output logic                       stream_done_o
);

  back_state_e           state_q, state_d;
  logic [COUNT_BITS-1:0] out_index_q, out_index_inc;
  logic [POS_W-1:0]      pos_q, pos_next;
  logic [IN_W-1:0]       in_index_q;
  logic [RUN_W-1:0]      run_q;
  logic [SAMPLE_W-1:0]   sample_q;
  logic                  active, more, last_out, fire;

  // A source word starts a run if outputs are still due and its slot is reached.
  assign active = (out_index_q < cfg_i.count) &&
                  (pos_q[POS_W-1:FRAC_BITS] <= in_index_q);

  // Whether another output follows the current one for this word.
  assign out_index_inc = out_index_q + 1'b1;
  assign pos_next      = pos_q + POS_W'(cfg_i.step);
  assign last_out      = (out_index_inc == cfg_i.count);
  assign more = (run_q != RUN_W'(MAX_RESULTS - 1)) && !last_out &&
                (pos_next[POS_W-1:FRAC_BITS] <= in_index_q);

  assign fire = out_valid_o && out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i && active) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_ready_i && !more) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      BK_IDLE: pop_o       = q_valid_i;
      BK_EMIT: out_valid_o = 1'b1;
      default: begin
        pop_o       = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  // Stream counters and the held source word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_index_q <= '0;
      pos_q       <= '0;
      in_index_q  <= '0;
      run_q       <= '0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        run_q <= '0;
        // A word that gives no output only moves the source index.
        if (!active && (in_index_q != '1)) begin
          in_index_q <= in_index_q + 1'b1;
        end
      end
      if (fire) begin
        out_index_q <= out_index_inc;
        pos_q       <= pos_next;
        run_q       <= run_q + 1'b1;
        if (!more && (in_index_q != '1)) begin
          in_index_q <= in_index_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sample_q <= q_sample_i;
    end
  end

  // Result word.
  assign sample_out_o   = signed'(sample_q);
  assign chunk_offset_o = out_index_q[OFS_W-1:0];
  assign chunk_start_o  = (out_index_q[OFS_W-1:0] == '0);
  assign run_last_o     = !more;
  assign stream_done_o  = last_out;

endmodule
